FILE: design/idr_pkg.sv
// Shared types, calibration curves and helper functions for the IR distance linearizer.
`timescale 1ns / 1ps

package idr_pkg;

    // Reading width, the widths that follow from it and the other data widths.
    localparam int ADC_BITS   = 10;
    localparam int S_TDATA_W  = ((ADC_BITS + 7) / 8) * 8;
    localparam int REM_W      = ADC_BITS + 4;
    localparam int QUO_W      = 4;
    localparam int DIST_W     = 9;
    localparam int M_TDATA_W  = ((DIST_W + 7) / 8) * 8;
    localparam int CURVE_W    = 10;
    localparam int IDX_W      = 5;
    localparam int DIV_CELLS  = QUO_W;

    localparam int ARM_POINTS  = 31;
    localparam int SIDE_POINTS = 26;
    localparam int MAX_POINTS  = 31;

    localparam logic [1:0] SEL_ARM   = 2'd0;
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;

    localparam logic [DIST_W-1:0] DIST_BASE = 9'd50;
    localparam logic [DIST_W-1:0] DIST_STEP = 9'd10;

    typedef logic [ADC_BITS-1:0] reading_t;
    typedef logic [REM_W-1:0]    rem_t;
    typedef logic [QUO_W-1:0]    quo_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CURVE_W-1:0]  curve_t;

    // Work carried along the divider chain.
    typedef struct packed {
        rem_t     rem;
        reading_t den;
        quo_t     quo;
        dist_t    base;
    } div_t;

    localparam curve_t ARM_CURVE [0:ARM_POINTS-1] = '{
        10'd610, 10'd610, 10'd598, 10'd547, 10'd495, 10'd456, 10'd416, 10'd388,
        10'd359, 10'd338, 10'd319, 10'd301, 10'd286, 10'd271, 10'd260, 10'd249,
        10'd240, 10'd229, 10'd221, 10'd212, 10'd204, 10'd195, 10'd187, 10'd183,
        10'd175, 10'd171, 10'd167, 10'd160, 10'd156, 10'd153, 10'd149};

    localparam curve_t LEFT_CURVE [0:SIDE_POINTS-1] = '{
        10'd490, 10'd406, 10'd365, 10'd322, 10'd290, 10'd265, 10'd240, 10'd224,
        10'd210, 10'd193, 10'd182, 10'd170, 10'd158, 10'd141, 10'd134, 10'd123,
        10'd112, 10'd109, 10'd97,  10'd89,  10'd80,  10'd75,  10'd71,  10'd63,
        10'd59,  10'd55};

    localparam curve_t RIGHT_CURVE [0:SIDE_POINTS-1] = '{
        10'd473, 10'd395, 10'd343, 10'd303, 10'd275, 10'd247, 10'd225, 10'd210,
        10'd193, 10'd177, 10'd161, 10'd145, 10'd133, 10'd121, 10'd106, 10'd95,
        10'd84,  10'd75,  10'd72,  10'd63,  10'd55,  10'd51,  10'd44,  10'd40,
        10'd38,  10'd37};

    function automatic reading_t curve_point(input logic [1:0] sel, input idx_t idx);
        curve_t pt;
        pt = '0;
        unique case (sel)
            SEL_ARM:
            begin
                if (int'(idx) < ARM_POINTS) pt = ARM_CURVE[idx];
            end
            SEL_LEFT:
            begin
                if (int'(idx) < SIDE_POINTS) pt = LEFT_CURVE[idx];
            end
            SEL_RIGHT:
            begin
                if (int'(idx) < SIDE_POINTS) pt = RIGHT_CURVE[idx];
            end
            default:
            begin
                pt = '0;
            end
        endcase
        return reading_t'(pt);
    endfunction

    function automatic idx_t point_count(input logic [1:0] sel);
        idx_t n;
        unique case (sel)
            SEL_ARM:   n = idx_t'(ARM_POINTS);
            SEL_LEFT:  n = idx_t'(SIDE_POINTS);
            SEL_RIGHT: n = idx_t'(SIDE_POINTS);
            default:   n = idx_t'(1);
        endcase
        return n;
    endfunction

    // Distance at curve point idx.
    function automatic dist_t point_dist(input idx_t idx);
        return DIST_BASE + dist_t'(idx) * DIST_STEP;
    endfunction

endpackage

FILE: design/idr_lookup.sv
// Front stage: curve search, clamping and setup of the ceiling division.
`timescale 1ns / 1ps

module idr_lookup (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  idr_pkg::reading_t ad_value,
    input  logic [1:0]        sensor_select,
    output logic              out_valid,
    input  logic              out_ready,
    output idr_pkg::div_t     out_data
);

    logic              valid_reg;
    idr_pkg::div_t     data_reg;
    idr_pkg::div_t     data_next;
    logic [idr_pkg::MAX_POINTS-1:0] hit;
    idr_pkg::idx_t     n;
    idr_pkg::idx_t     idx;
    idr_pkg::reading_t t_hi;
    idr_pkg::reading_t t_lo;
    idr_pkg::reading_t t_last;
    idr_pkg::reading_t num;
    idr_pkg::reading_t den;

    assign n = idr_pkg::point_count(sensor_select);

    // The curves fall, so the hit vector is a thermometer code.
    always_comb
    begin
        for (int i = 0; i < idr_pkg::MAX_POINTS; i++)
        begin
            hit[i] = (idr_pkg::idx_t'(i) >= n) ||
                     (ad_value >= idr_pkg::curve_point(sensor_select, idr_pkg::idx_t'(i)));
        end
    end

    always_comb
    begin
        idx = idr_pkg::idx_t'(1);
        for (int i = idr_pkg::MAX_POINTS - 1; i >= 1; i--)
        begin
            if (hit[i]) idx = idr_pkg::idx_t'(i);
        end
    end

    assign t_lo   = idr_pkg::curve_point(sensor_select, idx);
    assign t_hi   = idr_pkg::curve_point(sensor_select, idx - idr_pkg::idx_t'(1));
    assign t_last = idr_pkg::curve_point(sensor_select, n - idr_pkg::idx_t'(1));
    assign num    = ad_value - t_lo;
    assign den    = t_hi - t_lo;

    always_comb
    begin
        data_next.quo = '0;
        priority if (sensor_select != idr_pkg::SEL_ARM &&
                     sensor_select != idr_pkg::SEL_LEFT &&
                     sensor_select != idr_pkg::SEL_RIGHT)
        begin
            data_next.base = idr_pkg::DIST_BASE;
            data_next.rem  = '0;
            data_next.den  = idr_pkg::reading_t'(1);
        end
        else if (hit[0])
        begin
            data_next.base = idr_pkg::DIST_BASE;
            data_next.rem  = '0;
            data_next.den  = idr_pkg::reading_t'(1);
        end
        else if (ad_value <= t_last)
        begin
            data_next.base = idr_pkg::point_dist(n - idr_pkg::idx_t'(1));
            data_next.rem  = '0;
            data_next.den  = idr_pkg::reading_t'(1);
        end
        else
        begin
            // Ceiling of 10*num/den as floor((10*num + den - 1) / den).
            data_next.base = idr_pkg::point_dist(idx);
            data_next.rem  = idr_pkg::rem_t'(num) * idr_pkg::rem_t'(10)
                           + idr_pkg::rem_t'(den) - idr_pkg::rem_t'(1);
            data_next.den  = den;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: design/idr_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the remainder on.
`timescale 1ns / 1ps

module idr_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  idr_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output idr_pkg::div_t out_data
);

    logic          valid_reg;
    idr_pkg::div_t data_reg;
    idr_pkg::div_t data_next;
    idr_pkg::rem_t den_top;
    idr_pkg::rem_t diff;
    logic          take;

    // The remainder shifts left each cell, so the divisor is always
    // compared at the weight of the top quotient bit.
    assign den_top = idr_pkg::rem_t'({in_data.den, 3'b000});
    assign take    = in_data.rem >= den_top;
    assign diff    = take ? (in_data.rem - den_top) : in_data.rem;

    always_comb
    begin
        data_next      = in_data;
        data_next.rem  = {diff[idr_pkg::REM_W-2:0], 1'b0};
        data_next.quo  = {in_data.quo[idr_pkg::QUO_W-2:0], take};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: design/ir_distance_linearizer.sv
// Top level of the IR distance linearizer: lookup stage, divider chain and output register.
`timescale 1ns / 1ps
// A request accepted into the lookup register passes through the four divider cells
// and the output register before it shows on m_tvalid.
// One request per cycle when not stalled; each divider cell resolves one quotient bit.
// Reset clears all valid flags at once; the data registers are not reset.
// Every stage has its own valid flag, so bubbles close up while the output stalls.

module ir_distance_linearizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [idr_pkg::S_TDATA_W-1:0] s_tdata,   // ad_value, zero padding
    input  logic [1:0]                    s_tuser,   // sensor_select
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [idr_pkg::M_TDATA_W-1:0] m_tdata    // distance_mm, zero padding
);

    // Handshake signals of the chain; index 0 is the lookup stage output.
    logic          chain_valid [0:idr_pkg::DIV_CELLS];
    logic          chain_ready [0:idr_pkg::DIV_CELLS];
    idr_pkg::div_t chain_data  [0:idr_pkg::DIV_CELLS];

    logic          out_valid_reg;
    idr_pkg::dist_t out_dist_reg;
    idr_pkg::dist_t out_dist_next;
    logic          out_in_ready;

    idr_lookup u_lookup (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .ad_value      (s_tdata[idr_pkg::ADC_BITS-1:0]),
        .sensor_select (s_tuser),
        .out_valid     (chain_valid[0]),
        .out_ready     (chain_ready[0]),
        .out_data      (chain_data[0])
    );

    // A row of identical cells; each one settles one quotient bit, most
    // significant first, and hands the shifted remainder to its neighbor.
    for (genvar k = 0; k < idr_pkg::DIV_CELLS; k++)
    begin : g_cell
        idr_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // The quotient is the rounded-up fraction of one step, at most ten.
    assign out_dist_next = chain_data[idr_pkg::DIV_CELLS].base
                         - idr_pkg::dist_t'(chain_data[idr_pkg::DIV_CELLS].quo);

    assign out_in_ready = !out_valid_reg || m_tready;
    assign chain_ready[idr_pkg::DIV_CELLS] = out_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_in_ready)
        begin
            out_valid_reg <= chain_valid[idr_pkg::DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_in_ready && chain_valid[idr_pkg::DIV_CELLS])
        begin
            out_dist_reg <= out_dist_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = idr_pkg::M_TDATA_W'(out_dist_reg);

    // The finished quotient never exceeds one full step.
    a_quo_range : assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[idr_pkg::DIV_CELLS] |->
            chain_data[idr_pkg::DIV_CELLS].quo <= idr_pkg::quo_t'(10))
        else $error("divider quotient above ten");

    // Every delivered distance lies on the span of the curves.
    a_dist_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[idr_pkg::DIST_W-1:0] >= 9'd50 &&
                      m_tdata[idr_pkg::DIST_W-1:0] <= 9'd350))
        else $error("distance out of range");

    // With the output register empty the whole chain can move, so input is open.
    a_open_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A request entering the chain is never dropped by the lookup stage.
    a_lookup_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[0] && !chain_ready[0]) |=> chain_valid[0])
        else $error("lookup stage lost a request");

endmodule
